@@ hdl/lspq_pkg.sv @@
// Shared types and constants for the linear-scan priority queue.
package lspq_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int VALUE_W          = 32;
	localparam int PRIO_W           = 8;
	localparam int KIND_W           = 2;
	localparam int STATUS_W         = 2;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam kind_t KIND_ENQ  = 2'd0;
	localparam kind_t KIND_DEQ  = 2'd1;
	localparam kind_t KIND_PEEK = 2'd2;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_UNDERFLOW = 2'd1;
	localparam status_t STATUS_FULL      = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    enq_write;
		logic    set_status;
		status_t status_code;
		logic    scan_start;
		logic    scan_issue;
		logic    take_result;
		logic    shift_start;
		logic    shift_issue;
		logic    pop;
		logic    out_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  empty;
		logic  scan_last;
		logic  shift_done;
		logic  out_free;
	} dp_sts_t;

endpackage

@@ hdl/lspq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lspq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/lspq_dp.sv @@
// Datapath: entry storage, count, scan and shift address logic, result registers.
module lspq_dp #(
	parameter int CAPACITY = lspq_pkg::DEFAULT_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lspq_pkg::dp_cmd_t                   cmd,
	output lspq_pkg::dp_sts_t                   sts,
	input  lspq_pkg::kind_t                     kind,
	input  logic signed [lspq_pkg::VALUE_W-1:0] value,
	input  logic [lspq_pkg::PRIO_W-1:0]         prio,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [lspq_pkg::VALUE_W-1:0] result_value,
	output lspq_pkg::status_t                   status
);

	import lspq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = PRIO_W + VALUE_W;

	kind_t                     kind_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [PRIO_W-1:0]         prio_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic                      scan_s1;
	logic                      shift_s1;
	logic [AW-1:0]             pos_s1;
	logic [AW-1:0]             best_pos_q;
	logic [PRIO_W-1:0]         best_prio_q;
	logic signed [VALUE_W-1:0] res_value_q;
	status_t                   res_status_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	status_t                   out_status_q;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [EW-1:0]             ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [EW-1:0]             ram_rdata;
	logic [PRIO_W-1:0]         rd_prio;
	logic signed [VALUE_W-1:0] rd_value;

	assign rd_prio  = ram_rdata[EW-1 -: PRIO_W];
	assign rd_value = signed'(ram_rdata[VALUE_W-1:0]);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {prio_q, value_q};
		// Move each later entry down one position behind the removed one
		if (shift_s1) begin
			ram_we    = 1'b1;
			ram_waddr = pos_s1 - AW'(1);
			ram_wdata = ram_rdata;
		end else if (cmd.enq_write) begin
			ram_we = 1'b1;
		end
		ram_raddr = (cmd.scan_issue || cmd.shift_issue) ? idx_q[AW-1:0] : best_pos_q;
	end

	lspq_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		sts.kind       = kind_q;
		sts.full       = (count_q == CW'(CAPACITY));
		sts.empty      = (count_q == '0);
		sts.scan_last  = ((idx_q + CW'(1)) == count_q);
		sts.shift_done = (idx_q >= count_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			scan_s1     <= 1'b0;
			shift_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.enq_write) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.shift_start) begin
				idx_q <= CW'(best_pos_q) + CW'(1);
			end else if (cmd.scan_issue || cmd.shift_issue) begin
				idx_q <= idx_q + CW'(1);
			end
			scan_s1  <= cmd.scan_issue;
			shift_s1 <= cmd.shift_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q       <= kind;
			value_q      <= value;
			prio_q       <= prio;
			res_value_q  <= '0;
			res_status_q <= STATUS_OK;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status_code;
		end
		if (cmd.take_result) begin
			res_value_q <= rd_value;
		end
		if (cmd.scan_issue || cmd.shift_issue) begin
			pos_s1 <= idx_q[AW-1:0];
		end
		// Strict compare keeps the earliest arrival on a tie
		if (scan_s1 && (pos_s1 == '0 || rd_prio > best_prio_q)) begin
			best_pos_q  <= pos_s1;
			best_prio_q <= rd_prio;
		end
		if (cmd.out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;

endmodule

@@ hdl/lspq_ctrl.sv @@
// Controller state machine: sequences enqueue, scan, fetch, shift and response.
module lspq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lspq_pkg::dp_sts_t sts,
	output lspq_pkg::dp_cmd_t cmd
);

	import lspq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_FETCH_WAIT,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RESP;
				unique case (sts.kind) inside
					KIND_ENQ: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STATUS_FULL;
						end else begin
							cmd.enq_write = 1'b1;
						end
					end
					KIND_DEQ, KIND_PEEK: begin
						if (sts.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = STATUS_UNDERFLOW;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end
					end
					default: begin
						// Unknown operation: answer ok with zero
					end
				endcase
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_FETCH_WAIT;
			end
			ST_FETCH_WAIT: begin
				cmd.take_result = 1'b1;
				if (sts.kind == KIND_DEQ) begin
					cmd.shift_start = 1'b1;
					state_d         = ST_SHIFT;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_done) begin
					cmd.pop = 1'b1;
					state_d = ST_RESP;
				end else begin
					cmd.shift_issue = 1'b1;
				end
			end
			ST_RESP: begin
				// Hold until the output register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/linear_scan_priority_queue_unit.sv @@
// Sequence: enqueue and error cases go from decode straight to the response; peek scans
// every held entry and then reads the best one; dequeue does the same and then one RAM read
// and write per entry behind the removed one, all on the single entry RAM.
// One transaction at a time; the next is taken while the previous result waits.
// Reset (arst_n low, asynchronous) empties the queue; entry storage is not cleared.
module linear_scan_priority_queue_unit #(
	parameter int CAPACITY = lspq_pkg::DEFAULT_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  lspq_pkg::kind_t                     kind,
	input  logic signed [lspq_pkg::VALUE_W-1:0] value,
	input  logic [lspq_pkg::PRIO_W-1:0]         prio,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lspq_pkg::VALUE_W-1:0] result_value,
	output lspq_pkg::status_t                   status
);

	import lspq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	lspq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	lspq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.value       (value),
		.prio        (prio),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_value(result_value),
		.status      (status)
	);

endmodule
